### hw/rtl/ps2sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code decoder package
// Shared types, scan code constants and the key lookup table for the
// set 1 scan code to ASCII decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

	// Scan code set 1 bytes with special meaning.
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
	localparam logic [7:0] SC_KEY_M        = 8'h32;
	localparam logic [7:0] SC_KEY_N        = 8'h31;
	localparam logic [7:0] SC_KEY_P        = 8'h19;
	localparam logic [7:0] SC_ENTER        = 8'h1C;
	localparam logic [7:0] SC_BACKSPACE    = 8'h0E;

	// Characters produced by the fixed keys, and the bounds of the lower-case letter range.
	localparam logic [6:0] ASCII_LF    = 7'd10;
	localparam logic [6:0] ASCII_BS    = 7'd8;
	localparam logic [6:0] ASCII_LOW_A = 7'h61;
	localparam logic [6:0] ASCII_LOW_Z = 7'h7A;

	// Command carried with each input beat.
	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Media action codes.
	typedef enum logic [1:0] {
		MEDIA_NONE = 2'd0,
		MEDIA_MUTE = 2'd1,
		MEDIA_NEXT = 2'd2,
		MEDIA_PREV = 2'd3
	} media_t;

	// One input item.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] scan_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		media_t     media_action;
		logic [6:0] read_data;
	} result_t;

	// Lower-case key table for make codes 0x00 to 0x7F; zero means unmapped.
	function automatic logic [6:0] key_rom(input logic [6:0] idx);
		logic [6:0] ch;
		unique case (idx)
			7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
			7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
			7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;  7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;
			7'h39: ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

### hw/rtl/ps2sc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code decode stage
// Holds the shift, ctrl and latched key state and turns one registered
// input item into one result, updating the state when the item moves on.
// ----------------------------------------------------------------------------
module ps2sc_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  ps2sc_pkg::item_t   item,
	output ps2sc_pkg::result_t result
);

	logic       shift_q;
	logic       ctrl_q;
	logic [6:0] latched_q;
	logic       shift_d;
	logic       ctrl_d;
	logic [6:0] latched_d;
	logic [6:0] rom_ch;
	logic [6:0] base_ch;
	logic       is_lower;

	// Table lookup and fixed keys for a make code.
	always_comb begin
		rom_ch = ps2sc_pkg::key_rom(item.scan_byte[6:0]);
		if (item.scan_byte == ps2sc_pkg::SC_ENTER) begin
			base_ch = ps2sc_pkg::ASCII_LF;
		end else if (item.scan_byte == ps2sc_pkg::SC_BACKSPACE) begin
			base_ch = ps2sc_pkg::ASCII_BS;
		end else begin
			base_ch = rom_ch;
		end
		is_lower = (base_ch >= ps2sc_pkg::ASCII_LOW_A) && (base_ch <= ps2sc_pkg::ASCII_LOW_Z);
	end

	// Result and next state; modifiers are checked before the ctrl test.
	always_comb begin
		result              = '0;
		result.media_action = ps2sc_pkg::MEDIA_NONE;
		shift_d             = shift_q;
		ctrl_d              = ctrl_q;
		latched_d           = latched_q;
		priority if (item.cmd == ps2sc_pkg::CMD_READ) begin
			result.read_data = latched_q;
			latched_d        = '0;
		end else if (item.scan_byte == ps2sc_pkg::SC_LSHIFT_MAKE ||
				item.scan_byte == ps2sc_pkg::SC_RSHIFT_MAKE) begin
			shift_d = 1'b1;
		end else if (item.scan_byte == ps2sc_pkg::SC_LSHIFT_BREAK ||
				item.scan_byte == ps2sc_pkg::SC_RSHIFT_BREAK) begin
			shift_d = 1'b0;
		end else if (item.scan_byte == ps2sc_pkg::SC_CTRL_MAKE) begin
			ctrl_d = 1'b1;
		end else if (item.scan_byte == ps2sc_pkg::SC_CTRL_BREAK) begin
			ctrl_d = 1'b0;
		end else if (ctrl_q) begin
			// Ctrl chords map to media actions; anything else is swallowed.
			priority if (item.scan_byte == ps2sc_pkg::SC_KEY_M) begin
				result.media_action = ps2sc_pkg::MEDIA_MUTE;
			end else if (item.scan_byte == ps2sc_pkg::SC_KEY_N) begin
				result.media_action = ps2sc_pkg::MEDIA_NEXT;
			end else if (item.scan_byte == ps2sc_pkg::SC_KEY_P) begin
				result.media_action = ps2sc_pkg::MEDIA_PREV;
			end else begin
				result.media_action = ps2sc_pkg::MEDIA_NONE;
			end
		end else if (item.scan_byte[7]) begin
			// Break codes of ordinary keys produce nothing.
			result.media_action = ps2sc_pkg::MEDIA_NONE;
		end else if (base_ch != 7'd0) begin
			result.char_valid = 1'b1;
			// Clearing bit 5 upper-cases a letter.
			result.char_code  = (shift_q && is_lower) ? (base_ch & 7'h5F) : base_ch;
			latched_d         = result.char_code;
		end else begin
			result.media_action = ps2sc_pkg::MEDIA_NONE;
		end
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= 1'b0;
			ctrl_q    <= 1'b0;
			latched_q <= '0;
		end else if (advance) begin
			shift_q   <= shift_d;
			ctrl_q    <= ctrl_d;
			latched_q <= latched_d;
		end
	end

endmodule

### hw/rtl/ps2_scancode_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code set 1 to ASCII decoder
// Top level with input register, decode stage and result register.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless the sink stalls the
// result register: the beat is captured in an input register, decoded
// by the table lookup and modifier logic, and held in a result register until
// the sink takes it. Each input beat yields exactly one result beat. A read
// command returns the last character and clears it; ctrl chords give media
// actions instead of characters.
module ps2_scancode_to_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] scan_byte
	input  logic        s_tuser,  // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [6:0] char_code, [8:7] media_action, [15:9] read_data
	output logic        m_tuser   // [0] char_valid
);

	ps2sc_pkg::item_t   item_s1;
	logic               valid_s1;
	ps2sc_pkg::result_t res_d;
	ps2sc_pkg::result_t res_s2;
	logic               valid_s2;
	logic               adv_s1;

	// Stage 1 moves on when the result register is free or being drained.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd       <= ps2sc_pkg::cmd_t'(s_tuser);
			item_s1.scan_byte <= s_tdata;
		end
	end

	ps2sc_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(adv_s1),
		.item   (item_s1),
		.result (res_d)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.char_valid;
	assign m_tdata  = {res_s2.read_data, res_s2.media_action, res_s2.char_code};

endmodule

### hw/rtl/ps2sc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ps2sc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A character beat carries a nonzero code and nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[6:0] != 7'd0 && m_tdata[15:7] == 9'd0)
		else $error("character beat with stray fields");

	// Without a character the code field stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[6:0] == 7'd0)
		else $error("character code without a character");

	// A media action never comes with read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8:7] != 2'd0 |-> m_tdata[15:9] == 7'd0)
		else $error("media action together with read data");

endmodule

bind ps2_scancode_to_ascii ps2sc_checker u_ps2sc_checker (.*);
